@@ hw/rtl/sorted_top_k_insert_unit_macros.svh @@
// Assertion macros shared by the sorted top-k insert unit.
// Depends on nothing; the including module supplies clk and rst.
`ifndef SORTED_TOP_K_INSERT_UNIT_MACROS_SVH
`define SORTED_TOP_K_INSERT_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define STKI_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define STKI_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/stki_pkg.sv @@
// Shared types, sizes and helpers for the sorted top-k insert unit.
// Depends on nothing; used by every module of the unit.
`default_nettype none

package stki_pkg;

  // List geometry
  localparam int LIST_SIZE = 64;
  localparam int NUM_LISTS = 4;

  // Field widths
  localparam int SEL_W = 2;
  localparam int FIT_W = 32;
  localparam int ID_W  = 16;
  localparam int POS_W = 6;
  localparam int SUM_W = 38;

  typedef logic [SEL_W-1:0]        sel_t;
  typedef logic signed [FIT_W-1:0] fit_t;
  typedef logic [FIT_W-1:0]        mag_t;
  typedef logic [ID_W-1:0]         id_t;
  typedef logic [POS_W-1:0]        pos_t;
  typedef logic [SUM_W-1:0]        sum_t;

  // One slot as it moves down the chain
  typedef struct packed {
    logic valid;
    fit_t fit;
    id_t  id;
  } entry_t;

  // Update request to the running-sum bank
  typedef struct packed {
    logic upd;
    sel_t sel;
    mag_t add_abs;
    logic sub_valid;
    mag_t sub_abs;
  } sum_req_t;

  // Magnitude of a Q16.16 value; the most negative code gives 2^31
  function automatic mag_t fit_abs(fit_t f);
    fit_t neg;
    neg = -f;
    return f[FIT_W-1] ? mag_t'(neg) : mag_t'(f);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/stki_cell.sv @@
// One rank of the sorted chain: holds the slot of this rank for every list.
// Depends on stki_pkg.
`default_nettype none

module stki_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            upd,
  input  stki_pkg::sel_t  sel,
  input  stki_pkg::fit_t  new_fit,
  input  stki_pkg::id_t   new_id,
  input  logic            prev_ge,
  input  stki_pkg::entry_t prev_entry,
  output stki_pkg::entry_t cur,
  output logic            ge,
  output logic            take
);
  import stki_pkg::*;

  logic slot_valid [NUM_LISTS];
  fit_t slot_fit   [NUM_LISTS];
  id_t  slot_id    [NUM_LISTS];

  // Read the slot of the selected list
  assign cur.valid = slot_valid[sel];
  assign cur.fit   = slot_fit[sel];
  assign cur.id    = slot_id[sel];

  // Keep when at least as good; take the new entry at the boundary
  assign ge   = cur.valid && (cur.fit >= new_fit);
  assign take = !ge && prev_ge;

  // Valid flags clear on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < NUM_LISTS; l++) begin
        slot_valid[l] <= 1'b0;
      end
    end else if (upd && !ge) begin
      slot_valid[sel] <= take ? 1'b1 : prev_entry.valid;
    end
  end

  // Payload: land the new entry or shift the neighbor down
  always_ff @(posedge clk) begin
    if (upd && !ge) begin
      slot_fit[sel] <= take ? new_fit : prev_entry.fit;
      slot_id[sel]  <= take ? new_id  : prev_entry.id;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/stki_sum.sv @@
// Running absolute-fitness sums, one per list.
// Depends on stki_pkg.
`default_nettype none

module stki_sum (
  input  logic              clk,
  input  logic              rst,
  input  stki_pkg::sum_req_t req,
  output stki_pkg::sum_t    sum_sel
);
  import stki_pkg::*;

  sum_t sums [NUM_LISTS];
  sum_t sum_cur;
  sum_t sum_next;

  // Drop the evicted magnitude, add the new one, wrap at the sum width
  assign sum_cur  = sums[req.sel];
  assign sum_next = sum_cur
                    - (req.sub_valid ? SUM_W'(req.sub_abs) : '0)
                    + SUM_W'(req.add_abs);
  assign sum_sel  = req.upd ? sum_next : sum_cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < NUM_LISTS; l++) begin
        sums[l] <= '0;
      end
    end else if (req.upd) begin
      sums[req.sel] <= sum_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/sorted_top_k_insert_unit.sv @@
// Top level of the sorted top-k insert unit: input stage, chain of rank
// cells, running-sum bank and result register.
// Depends on stki_pkg, stki_cell, stki_sum and the unit's macro header.
//
//   channel | valid        | stall        | beat fields
//   --------+--------------+--------------+---------------------------------------
//   item    | item_valid   | item_stall   | list_select, fitness, entry_id
//   result  | result_valid | result_stall | accepted, position, evicted_valid,
//           |              |              | evicted_id, best_fitness, abs_fitness_sum
//
// An item beat is registered in the input stage; every rank cell then compares its
// slot against the new fitness and all cells update together, and the outcome is
// registered in the result register. One item per cycle is sustained while the
// result is not stalled.
// Reset clears all slot valid flags and the sums.
// A stalled result holds the result register and the input stage.
`default_nettype none
`include "sorted_top_k_insert_unit_macros.svh"

module sorted_top_k_insert_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  stki_pkg::sel_t list_select,
  input  stki_pkg::fit_t fitness,
  input  stki_pkg::id_t  entry_id,
  output logic           result_valid,
  input  logic           result_stall,
  output logic           accepted,
  output stki_pkg::pos_t position,
  output logic           evicted_valid,
  output stki_pkg::id_t  evicted_id,
  output stki_pkg::fit_t best_fitness,
  output stki_pkg::sum_t abs_fitness_sum
);
  import stki_pkg::*;

  localparam int LAST = LIST_SIZE - 1;

  // Input stage
  logic p_valid;
  sel_t p_sel;
  fit_t p_fit;
  id_t  p_id;
  logic adv;

  entry_t          cur  [LIST_SIZE];
  logic [LIST_SIZE-1:0] ge;
  logic [LIST_SIZE-1:0] take;

  logic     in_range;
  logic     accept;
  logic     upd;
  logic     ev_valid;
  pos_t     pos_enc;
  fit_t     best_next;
  sum_req_t sreq;
  sum_t     sum_sel;

  assign adv        = p_valid && (!result_valid || !result_stall);
  assign item_stall = p_valid && !adv;

  // Capture an item beat when the stage is free or moving on
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (!p_valid || adv) begin
      p_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!p_valid || adv) begin
      p_sel <= list_select;
      p_fit <= fitness;
      p_id  <= entry_id;
    end
  end

  // Chain of rank cells, best rank first
  for (genvar k = 0; k < LIST_SIZE; k++) begin : g_rank
    if (k == 0) begin : g_head
      entry_t head_in;
      assign head_in = '{valid: 1'b1, fit: p_fit, id: p_id};
      stki_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .upd        (upd),
        .sel        (p_sel),
        .new_fit    (p_fit),
        .new_id     (p_id),
        .prev_ge    (1'b1),
        .prev_entry (head_in),
        .cur        (cur[k]),
        .ge         (ge[k]),
        .take       (take[k])
      );
    end else begin : g_body
      stki_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .upd        (upd),
        .sel        (p_sel),
        .new_fit    (p_fit),
        .new_id     (p_id),
        .prev_ge    (ge[k-1]),
        .prev_entry (cur[k-1]),
        .cur        (cur[k]),
        .ge         (ge[k]),
        .take       (take[k])
      );
    end
  end

  // Accept when the worst slot is empty or strictly worse
  assign in_range = (32'(p_sel) < NUM_LISTS);
  assign accept   = in_range && !ge[LAST];
  assign upd      = adv && accept;
  assign ev_valid = accept && cur[LAST].valid;

  // Encode the landing rank
  always_comb begin
    pos_enc = '0;
    for (int k = 0; k < LIST_SIZE; k++) begin
      if (take[k]) begin
        pos_enc = pos_enc | POS_W'(k);
      end
    end
  end

  // Best slot after the step; an empty slot reads as zero
  always_comb begin
    if (accept && take[0]) begin
      best_next = p_fit;
    end else if (cur[0].valid) begin
      best_next = cur[0].fit;
    end else begin
      best_next = '0;
    end
  end

  assign sreq.upd       = upd;
  assign sreq.sel       = p_sel;
  assign sreq.add_abs   = fit_abs(p_fit);
  assign sreq.sub_valid = ev_valid;
  assign sreq.sub_abs   = fit_abs(cur[LAST].fit);

  stki_sum u_sum (
    .clk     (clk),
    .rst     (rst),
    .req     (sreq),
    .sum_sel (sum_sel)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      accepted        <= accept;
      position        <= accept ? pos_enc : '0;
      evicted_valid   <= ev_valid;
      evicted_id      <= ev_valid ? cur[LAST].id : '0;
      best_fitness    <= in_range ? best_next : '0;
      abs_fitness_sum <= in_range ? sum_sel : '0;
    end
  end

  // Checks on the chain and the result
  `STKI_ASSERT_ALWAYS(a_take_onehot0, $onehot0(take), "more than one rank takes the new entry")
  `STKI_ASSERT(a_stall_needs_item, item_stall |-> p_valid, "input stalled with an empty stage")
  `STKI_ASSERT(a_evict_needs_accept, (result_valid && evicted_valid) |-> accepted,
               "eviction reported for a rejected entry")
  `STKI_ASSERT(a_reject_clean, (result_valid && !accepted) |-> (position == '0 && evicted_id == '0),
               "rejected entry reports a position or an evicted id")
  `STKI_ASSERT(a_upd_lands, upd |-> (take != '0), "accepted entry finds no rank")

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking bench for sorted_top_k_insert_unit: directed and random inserts
// with random idle and stall bursts, checked against a behavioral list model.
// Depends on stki_pkg and the sorted_top_k_insert_unit RTL.
`timescale 1ns / 100ps

module tb;
  import stki_pkg::*;

  localparam int LAST       = LIST_SIZE - 1;
  localparam int QUIET_MAX  = 2000;
  localparam int N_RANDOM   = 800;
  localparam int CALM_TAIL  = 120;

  typedef struct {
    sel_t sel;
    fit_t fit;
    id_t  id;
    bit   drain;
  } insert_req_t;

  typedef struct packed {
    logic accepted;
    pos_t position;
    logic evicted_valid;
    id_t  evicted_id;
    fit_t best_fitness;
    sum_t abs_fitness_sum;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  sel_t list_select = '0;
  fit_t fitness = '0;
  id_t  entry_id = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic accepted;
  pos_t position;
  logic evicted_valid;
  id_t  evicted_id;
  fit_t best_fitness;
  sum_t abs_fitness_sum;

  // Shadow copy of every list and its running magnitude sum
  fit_t rank_fit  [NUM_LISTS][LIST_SIZE] = '{default: '0};
  id_t  rank_id   [NUM_LISTS][LIST_SIZE] = '{default: '0};
  bit   rank_used [NUM_LISTS][LIST_SIZE] = '{default: 1'b0};
  sum_t lane_sum  [NUM_LISTS] = '{default: '0};

  insert_req_t pending_items[$];
  outcome_t    insert_outcomes[$];

  int item_total = 0;
  int items_offered = 0;
  int items_sent = 0;
  int results_got = 0;
  int gap_left = 0;
  int stall_left = 0;
  int fail_count = 0;

  sorted_top_k_insert_unit DUT (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .list_select     (list_select),
    .fitness         (fitness),
    .entry_id        (entry_id),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .accepted        (accepted),
    .position        (position),
    .evicted_valid   (evicted_valid),
    .evicted_id      (evicted_id),
    .best_fitness    (best_fitness),
    .abs_fitness_sum (abs_fitness_sum)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Q16.16 magnitude; the most negative code yields 2^31
  function automatic sum_t magnitude(fit_t f);
    longint v;
    v = f;
    return sum_t'(v < 0 ? -v : v);
  endfunction

  // Apply one insert to the shadow lists and return the outcome it produces
  function automatic outcome_t predict_insert(sel_t sel, fit_t fit, id_t id);
    outcome_t o;
    int slot;
    sum_t run;
    o = '0;
    if (!rank_used[sel][LAST] || fit > rank_fit[sel][LAST]) begin
      run = lane_sum[sel];
      if (rank_used[sel][LAST]) begin
        o.evicted_valid = 1'b1;
        o.evicted_id = rank_id[sel][LAST];
        run = run - magnitude(rank_fit[sel][LAST]);
      end
      lane_sum[sel] = run + magnitude(fit);
      // land below every occupied slot of equal or better fitness
      slot = 0;
      while (slot < LAST && rank_used[sel][slot] && rank_fit[sel][slot] >= fit)
        slot++;
      for (int k = LAST; k > slot; k--) begin
        rank_fit[sel][k]  = rank_fit[sel][k-1];
        rank_id[sel][k]   = rank_id[sel][k-1];
        rank_used[sel][k] = rank_used[sel][k-1];
      end
      rank_fit[sel][slot]  = fit;
      rank_id[sel][slot]   = id;
      rank_used[sel][slot] = 1'b1;
      o.accepted = 1'b1;
      o.position = pos_t'(slot);
    end
    o.best_fitness = rank_fit[sel][0];
    o.abs_fitness_sum = lane_sum[sel];
    return o;
  endfunction

  task automatic add_item(int sel, logic [31:0] fit, int id, bit drain = 1'b0);
    insert_req_t r;
    r.sel = sel_t'(sel);
    r.fit = fit_t'(fit);
    r.id = id_t'(id);
    r.drain = drain;
    pending_items.push_back(r);
  endtask

  // Mix wide random values, a small tie-prone pool, the extremes and a narrow band near zero
  function automatic fit_t pick_fitness();
    int roll;
    int k;
    roll = $urandom_range(0, 19);
    if (roll < 8) begin
      return fit_t'($urandom());
    end else if (roll < 14) begin
      k = $urandom_range(0, 16);
      return fit_t'((k - 8) * 65536);
    end else if (roll < 16) begin
      case ($urandom_range(0, 4))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        3: return 32'hFFFF_FFFF;
        default: return 32'h8000_0001;
      endcase
    end else begin
      k = $urandom_range(0, 1 << 20);
      return fit_t'(k - (1 << 19));
    end
  endfunction

  // Build the item list, release reset, then wait for the last result
  initial begin
    // extremes, ties and every list
    add_item(0, 32'h7FFF_FFFF, 16'hFFFF);
    add_item(0, 32'h8000_0000, 16'h0000);
    add_item(0, 32'h0000_0000, 16'h0001);
    add_item(0, 32'hFFFF_FFFF, 16'h0002);
    add_item(0, 32'h0000_0001, 16'h0003);
    add_item(0, 32'h8000_0001, 16'h0004);
    add_item(0, 32'h7FFF_FFFE, 16'h0005);
    add_item(0, 32'h0000_0000, 16'h0006);
    add_item(0, 32'h7FFF_FFFF, 16'h0007);
    add_item(1, 32'h0001_0000, 16'h1234);
    add_item(1, 32'h0001_0000, 16'h4321);
    add_item(1, 32'hFFFF_0000, 16'h8000);
    add_item(2, 32'h8000_0000, 16'h00FF);
    add_item(2, 32'h8000_0000, 16'hFF00);
    add_item(2, 32'h7FFF_FFFF, 16'h7FFF);
    add_item(3, 32'h7FFF_0000, 16'hAAAA);
    add_item(3, 32'h8000_0001, 16'h5555);
    add_item(3, 32'h5555_5555, 16'h0F0F);
    add_item(3, 32'hAAAA_AAAA, 16'hF0F0);
    for (int i = 0; i < N_RANDOM; i++)
      add_item($urandom_range(0, NUM_LISTS - 1), pick_fitness(), $urandom_range(0, 65535),
               i == 0 || $urandom_range(0, 119) == 0);
    item_total = pending_items.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || insert_outcomes.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Drive item beats: hold while stalled, otherwise idle or present the next
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (items_offered == items_sent) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        item_valid <= 1'b0;
      end else if (pending_items.size() == 0) begin
        item_valid <= 1'b0;
      end else if (pending_items[0].drain && insert_outcomes.size() != 0) begin
        item_valid <= 1'b0;
      end else if (!((items_sent >= 300 && items_sent < 380) ||
                     items_sent + CALM_TAIL >= item_total) &&
                   $urandom_range(1, 6) == 1) begin
        gap_left <= $urandom_range(0, 8);
        item_valid <= 1'b0;
      end else begin
        item_valid <= 1'b1;
        list_select <= pending_items[0].sel;
        fitness <= pending_items[0].fit;
        entry_id <= pending_items[0].id;
        items_offered <= items_offered + 1;
      end
    end
  end

  // Stall results in random bursts, none in the calm stretches
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      result_stall <= 1'b1;
    end else if (!((results_got >= 500 && results_got < 580) ||
                   results_got + CALM_TAIL >= item_total) &&
                 $urandom_range(1, 6) == 1) begin
      stall_left <= $urandom_range(0, 8);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Predict the outcome of each item beat as it is taken
  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall) begin
      insert_outcomes.push_back(predict_insert(list_select, fitness, entry_id));
      void'(pending_items.pop_front());
      items_sent <= items_sent + 1;
    end
  end

  // Compare each result beat with the oldest predicted outcome
  always @(posedge clk) begin : result_check
    outcome_t got;
    outcome_t want;
    if (!rst && result_valid && !result_stall) begin
      results_got <= results_got + 1;
      got = '{accepted, position, evicted_valid, evicted_id, best_fitness, abs_fitness_sum};
      if (insert_outcomes.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("result beat with no item pending: acc=%0b pos=%0d ev=%0b evid=%h",
                   got.accepted, got.position, got.evicted_valid, got.evicted_id);
      end else begin
        want = insert_outcomes.pop_front();
        if (got.accepted !== want.accepted || got.position !== want.position ||
            got.evicted_valid !== want.evicted_valid || got.evicted_id !== want.evicted_id ||
            got.best_fitness !== want.best_fitness ||
            got.abs_fitness_sum !== want.abs_fitness_sum) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch on result %0d: exp acc=%0b pos=%0d ev=%0b evid=%h best=%h sum=%h",
                     results_got, want.accepted, want.position, want.evicted_valid,
                     want.evicted_id, want.best_fitness, want.abs_fitness_sum);
            $display("                         got acc=%0b pos=%0d ev=%0b evid=%h best=%h sum=%h",
                     got.accepted, got.position, got.evicted_valid,
                     got.evicted_id, got.best_fitness, got.abs_fitness_sum);
          end
        end
      end
    end
  end

  // End the run if neither channel moves a beat for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_MAX) begin
      @(posedge clk);
      if ((item_valid && !item_stall) || (result_valid && !result_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILURE");
    $finish;
  end

endmodule
